FILE: rtl/core/dgt_pkg.sv
// ----------------------------------------------------------------------------
// dgt_pkg
// Shared constants, types and helpers of the depth grid triangulator.
// ----------------------------------------------------------------------------
package dgt_pkg;

  localparam int COLUMNS = 640;
  localparam int ROWS    = 480;

  localparam int COORD_W  = 14;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int DIST_W   = SQ_W + 2;
  localparam int THRESH_W = 20;
  localparam int IDX_W    = 19;
  localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(100);

  // Job queue between the front and the back.
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // One grid cell that passed at least one triangle test.
  typedef struct packed {
    logic [IDX_W-1:0] ul_idx;
    logic [IDX_W-1:0] ll_idx;
    logic [IDX_W-1:0] ur_idx;
    logic [IDX_W-1:0] lr_idx;
    logic             tri1_ok;
    logic             tri2_ok;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  function automatic logic [SQ_W-1:0] sq_diff(input logic signed [COORD_W-1:0] a,
                                              input logic signed [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0]   d;
    logic signed [2*DIFF_W-1:0] p;
    d = DIFF_W'(a) - DIFF_W'(b);
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

endpackage

FILE: rtl/core/dgt_if.sv
// ----------------------------------------------------------------------------
// dgt_if
// Valid/ready channels for incoming points and outgoing triangles.
// ----------------------------------------------------------------------------
interface dgt_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [dgt_pkg::COORD_W-1:0]  point_x;
  logic signed [dgt_pkg::COORD_W-1:0]  point_y;
  logic signed [dgt_pkg::COORD_W-1:0]  point_z;
  logic                                frame_start;

  modport source (output valid, point_x, point_y, point_z, frame_start, input ready);
  modport sink   (input valid, point_x, point_y, point_z, frame_start, output ready);
endinterface

interface dgt_tri_if;
  logic                        valid;
  logic                        ready;
  logic [dgt_pkg::IDX_W-1:0]   corner_a;
  logic [dgt_pkg::IDX_W-1:0]   corner_b;
  logic [dgt_pkg::IDX_W-1:0]   corner_c;
  logic                        last_of_run;

  modport source (output valid, corner_a, corner_b, corner_c, last_of_run, input ready);
  modport sink   (input valid, corner_a, corner_b, corner_c, last_of_run, output ready);
endinterface

FILE: rtl/core/depth_grid_triangulator.sv
// ----------------------------------------------------------------------------
// depth_grid_triangulator
// Builds a triangle mesh from an organized depth point stream in raster order.
// ----------------------------------------------------------------------------
//  Channel     Dir  Handshake     Payload
//  points      in   valid/ready   point_x, point_y, point_z, frame_start
//  triangles   out  valid/ready   corner_a, corner_b, corner_c, last_of_run
//  cfg         in   cfg_write     cfg_data = edge_threshold
//
//  One point is taken per cycle while the job queue has room for every point
//  still in the two-stage test pipeline; a cell is registered in s1 and s2
//  before it enters the queue. The output register sends one triangle per
//  cycle while not stalled; a point with two triangles holds it for both.
//  Reset clears counters, queue and output valid; the line store is not
//  cleared and needs no clearing pass. An output stall backs up through the
//  queue to points.ready.
// ----------------------------------------------------------------------------
module depth_grid_triangulator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [dgt_pkg::THRESH_W-1:0]  cfg_data,
  dgt_point_if.sink                     points,
  dgt_tri_if.source                     triangles
);

  dgt_pkg::push_t              push;
  dgt_pkg::head_t              head;
  logic                        pop;
  logic [dgt_pkg::FILL_W-1:0]  fill;

  dgt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .points    (points),
    .fill      (fill),
    .push      (push)
  );

  dgt_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .fill (fill)
  );

  dgt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .triangles (triangles)
  );

endmodule

FILE: rtl/core/dgt_front.sv
// ----------------------------------------------------------------------------
// dgt_front
// Accepts points, tracks raster position, keeps the previous row and tests
// the two triangles of each completed grid cell.
// ----------------------------------------------------------------------------
module dgt_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [dgt_pkg::THRESH_W-1:0]    cfg_data,
  dgt_point_if.sink                       points,
  input  logic [dgt_pkg::FILL_W-1:0]      fill,
  output dgt_pkg::push_t                  push
);

  localparam logic [dgt_pkg::COL_W-1:0] COL_LAST = dgt_pkg::COL_W'(dgt_pkg::COLUMNS - 1);
  localparam logic [dgt_pkg::ROW_W-1:0] ROW_LAST = dgt_pkg::ROW_W'(dgt_pkg::ROWS - 1);
  localparam logic [dgt_pkg::IDX_W-1:0] IDX_COLS = dgt_pkg::IDX_W'(dgt_pkg::COLUMNS);
  localparam logic [dgt_pkg::IDX_W-1:0] IDX_COLS1 = dgt_pkg::IDX_W'(dgt_pkg::COLUMNS + 1);
  localparam logic [dgt_pkg::FILL_W:0]  DEPTH_C = (dgt_pkg::FILL_W + 1)'(dgt_pkg::FIFO_DEPTH);
  localparam int NE = 5;

  logic [dgt_pkg::THRESH_W-1:0] threshold;
  logic [dgt_pkg::COL_W-1:0]    column_count;
  logic [dgt_pkg::ROW_W-1:0]    row_count;
  logic [dgt_pkg::COL_W-1:0]    col_in;
  logic [dgt_pkg::ROW_W-1:0]    row_in;
  logic [dgt_pkg::FILL_W:0]     in_flight;
  logic                         accept;
  dgt_pkg::point_t              cur_in;

  dgt_pkg::point_t              row_store [dgt_pkg::COLUMNS];
  dgt_pkg::point_t              ur_q;

  logic                         s1_valid;
  logic                         s1_cell;
  logic [dgt_pkg::IDX_W-1:0]    s1_lr;
  dgt_pkg::point_t              s1_cur;
  dgt_pkg::point_t              s1_left;
  dgt_pkg::point_t              s1_ul;

  logic                         s2_valid;
  logic                         s2_cell;
  logic [dgt_pkg::IDX_W-1:0]    s2_lr;
  logic [dgt_pkg::SQ_W-1:0]     s2_sq [NE][3];

  logic [dgt_pkg::DIST_W-1:0]   edge_len [NE];
  logic [NE-1:0]                short_edge;
  logic                         tri1_ok;
  logic                         tri2_ok;

  dgt_pkg::point_t              ea [NE];
  dgt_pkg::point_t              eb [NE];

  assign cur_in = '{x: points.point_x, y: points.point_y, z: points.point_z};
  assign col_in = points.frame_start ? '0 : column_count;
  assign row_in = points.frame_start ? '0 : row_count;

  // Every item in the pipeline may still need a queue slot.
  assign in_flight = {1'b0, fill} + (dgt_pkg::FILL_W + 1)'(s1_valid)
                   + (dgt_pkg::FILL_W + 1)'(s2_valid);
  assign points.ready = in_flight < DEPTH_C;
  assign accept = points.valid && points.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= dgt_pkg::THRESH_RESET;
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        threshold <= cfg_data;
      end
      if (accept) begin
        if (col_in == COL_LAST) begin
          column_count <= '0;
          row_count    <= (row_in == ROW_LAST) ? '0 : row_in + 1'b1;
        end else begin
          column_count <= col_in + 1'b1;
          row_count    <= row_in;
        end
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  // Line store: the old entry is read out while the new point replaces it.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_store[col_in] <= cur_in;
      ur_q              <= row_store[col_in];
    end
  end

  // The previous item's point and upper right neighbor become this item's
  // left and upper left neighbors.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur  <= cur_in;
      s1_left <= s1_cur;
      s1_ul   <= ur_q;
      s1_cell <= (row_in != '0) && (col_in != '0);
      s1_lr   <= dgt_pkg::IDX_W'(row_in) * IDX_COLS + dgt_pkg::IDX_W'(col_in);
    end
  end

  // Edges: ul-left, left-cur, ul-cur, ul-ur, ur-cur.
  assign ea[0] = s1_ul;   assign eb[0] = s1_left;
  assign ea[1] = s1_left; assign eb[1] = s1_cur;
  assign ea[2] = s1_ul;   assign eb[2] = s1_cur;
  assign ea[3] = s1_ul;   assign eb[3] = ur_q;
  assign ea[4] = ur_q;    assign eb[4] = s1_cur;

  always_ff @(posedge clk) begin
    s2_cell <= s1_cell;
    s2_lr   <= s1_lr;
    for (int k = 0; k < NE; k++) begin
      s2_sq[k][0] <= dgt_pkg::sq_diff(ea[k].x, eb[k].x);
      s2_sq[k][1] <= dgt_pkg::sq_diff(ea[k].y, eb[k].y);
      s2_sq[k][2] <= dgt_pkg::sq_diff(ea[k].z, eb[k].z);
    end
  end

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      edge_len[k] = dgt_pkg::DIST_W'(s2_sq[k][0]) + dgt_pkg::DIST_W'(s2_sq[k][1])
                  + dgt_pkg::DIST_W'(s2_sq[k][2]);
      short_edge[k] = edge_len[k] < dgt_pkg::DIST_W'(threshold);
    end
  end

  assign tri1_ok = short_edge[0] && short_edge[1] && short_edge[2];
  assign tri2_ok = short_edge[3] && short_edge[4] && short_edge[2];

  assign push.valid       = s2_valid && s2_cell && (tri1_ok || tri2_ok);
  assign push.job.ul_idx  = s2_lr - IDX_COLS1;
  assign push.job.ll_idx  = s2_lr - dgt_pkg::IDX_W'(1);
  assign push.job.ur_idx  = s2_lr - IDX_COLS;
  assign push.job.lr_idx  = s2_lr;
  assign push.job.tri1_ok = tri1_ok;
  assign push.job.tri2_ok = tri2_ok;

endmodule

FILE: rtl/core/dgt_fifo.sv
// ----------------------------------------------------------------------------
// dgt_fifo
// Short job queue that decouples cell testing from triangle output.
// ----------------------------------------------------------------------------
module dgt_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  dgt_pkg::push_t              push,
  input  logic                        pop,
  output dgt_pkg::head_t              head,
  output logic [dgt_pkg::FILL_W-1:0]  fill
);

  dgt_pkg::job_t              entries [dgt_pkg::FIFO_DEPTH];
  logic [dgt_pkg::PTR_W-1:0]  wr_ptr;
  logic [dgt_pkg::PTR_W-1:0]  rd_ptr;
  logic                       do_pop;

  assign do_pop = pop && (fill != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + dgt_pkg::FILL_W'(push.valid) - dgt_pkg::FILL_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.job;
    end
  end

  assign head.valid = fill != '0;
  assign head.job   = entries[rd_ptr];

endmodule

FILE: rtl/core/dgt_back.sv
// ----------------------------------------------------------------------------
// dgt_back
// Turns queued cells into one or two triangles on the output channel.
// ----------------------------------------------------------------------------
module dgt_back (
  input  logic            clk,
  input  logic            rst,
  input  dgt_pkg::head_t  head,
  output logic            pop,
  dgt_tri_if.source       triangles
);

  logic tri2_phase;
  logic load;
  logic pick_tri1;
  logic is_last;

  assign load      = head.valid && (!triangles.valid || triangles.ready);
  assign pick_tri1 = head.job.tri1_ok && !tri2_phase;
  assign is_last   = pick_tri1 ? !head.job.tri2_ok : 1'b1;
  assign pop       = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      triangles.valid <= 1'b0;
      tri2_phase      <= 1'b0;
    end else begin
      if (load) begin
        triangles.valid <= 1'b1;
        tri2_phase      <= !is_last;
      end else if (triangles.ready) begin
        triangles.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      triangles.corner_a    <= head.job.ul_idx;
      triangles.corner_b    <= pick_tri1 ? head.job.ll_idx : head.job.ur_idx;
      triangles.corner_c    <= head.job.lr_idx;
      triangles.last_of_run <= is_last;
    end
  end

endmodule

FILE: sim/dgt_mesh_checker.sv
// ----------------------------------------------------------------------------
// dgt_mesh_checker
// Watches the point and triangle channels, predicts the triangles that each
// accepted point must produce, and compares every triangle that leaves the
// block against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module dgt_mesh_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [dgt_pkg::THRESH_W-1:0]  cfg_data,
  dgt_point_if                          points,
  dgt_tri_if                            triangles,
  output int                            fail_count,
  output int                            outstanding
);
  import dgt_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] corner_a;
    logic [IDX_W-1:0] corner_b;
    logic [IDX_W-1:0] corner_c;
    logic             last_of_run;
  } mesh_tri_t;

  point_t              prev_row [COLUMNS];
  point_t              left_pt;
  point_t              up_left_pt;
  int unsigned         col_pos;
  int unsigned         row_pos;
  logic [THRESH_W-1:0] edge_limit;
  mesh_tri_t           tri_q [$];
  int                  errors = 0;
  int                  tri_count = 0;

  function automatic longint span_sq(input point_t p, input point_t q);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'($signed(p.x)) - longint'($signed(q.x));
    dy = longint'($signed(p.y)) - longint'($signed(q.y));
    dz = longint'($signed(p.z)) - longint'($signed(q.z));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic bit short_edges(input point_t p, input point_t q, input point_t s);
    longint lim;
    lim = longint'(edge_limit);
    return span_sq(p, q) < lim && span_sq(q, s) < lim && span_sq(p, s) < lim;
  endfunction

  task automatic report(input string msg);
    errors++;
    $display("ERROR [%0t] %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [IDX_W-1:0] got,
                             input logic [IDX_W-1:0] want);
    if (got !== want)
      report($sformatf("triangle %0d %s: got %0d, expected %0d", tri_count, name, got, want));
  endtask

  // Queues the triangles of the cell whose lower right corner is this point.
  task automatic take_pixel(input point_t cur, input logic fs);
    point_t           above;
    int unsigned      r;
    int unsigned      c;
    logic [IDX_W-1:0] ul_i;
    logic [IDX_W-1:0] ll_i;
    logic [IDX_W-1:0] ur_i;
    logic [IDX_W-1:0] lr_i;
    bit               pass_low;
    bit               pass_high;
    mesh_tri_t        t;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    above = prev_row[c];
    if (r >= 1 && c >= 1) begin
      ul_i = IDX_W'((r - 1) * COLUMNS + c - 1);
      ll_i = IDX_W'(r * COLUMNS + c - 1);
      ur_i = IDX_W'((r - 1) * COLUMNS + c);
      lr_i = IDX_W'(r * COLUMNS + c);
      pass_low  = short_edges(up_left_pt, left_pt, cur);
      pass_high = short_edges(up_left_pt, above, cur);
      if (pass_low) begin
        t = '{corner_a: ul_i, corner_b: ll_i, corner_c: lr_i, last_of_run: !pass_high};
        tri_q.push_back(t);
      end
      if (pass_high) begin
        t = '{corner_a: ul_i, corner_b: ur_i, corner_c: lr_i, last_of_run: 1'b1};
        tri_q.push_back(t);
      end
    end
    up_left_pt  = above;
    left_pt     = cur;
    prev_row[c] = cur;
    c++;
    if (c >= COLUMNS) begin
      c = 0;
      r++;
      if (r >= ROWS) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic take_triangle();
    mesh_tri_t got;
    mesh_tri_t want;
    got = {triangles.corner_a, triangles.corner_b, triangles.corner_c, triangles.last_of_run};
    if (tri_q.size() == 0) begin
      report($sformatf("triangle %0d (%0d %0d %0d) arrived with none expected",
                       tri_count, got.corner_a, got.corner_b, got.corner_c));
    end else begin
      want = tri_q.pop_front();
      check_field("corner_a", got.corner_a, want.corner_a);
      check_field("corner_b", got.corner_b, want.corner_b);
      check_field("corner_c", got.corner_c, want.corner_c);
      check_field("last_of_run", IDX_W'(got.last_of_run), IDX_W'(want.last_of_run));
    end
    tri_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (prev_row[i]) prev_row[i] = '0;
      left_pt    = '0;
      up_left_pt = '0;
      col_pos    = 0;
      row_pos    = 0;
      edge_limit = THRESH_RESET;
      tri_q.delete();
    end else begin
      if (cfg_write) edge_limit = cfg_data;
      if (points.valid && points.ready)
        take_pixel({points.point_x, points.point_y, points.point_z}, points.frame_start);
      if (triangles.valid && triangles.ready) take_triangle();
    end
    outstanding <= tri_q.size();
    fail_count  <= errors;
  end

endmodule

FILE: sim/depth_grid_triangulator_tb.sv
// ----------------------------------------------------------------------------
// depth_grid_triangulator_tb
// Streams depth points into the triangulator: a hand-built opening row and a
// bit with extreme and borderline points, random surface segments under
// changing edge limits, then an early frame restart. Both channels stall at
// random; a checker predicts and compares every triangle.
// ----------------------------------------------------------------------------
module depth_grid_triangulator_tb;
  import dgt_pkg::*;

  localparam int MAX_GAP        = 12;
  localparam int SETTLE_CYCLES  = 16;
  localparam int IDLE_LIMIT     = 2000;
  localparam int TOTAL_ITEMS    = 950;
  localparam int RESTART_ITEMS  = 20;
  localparam int OPENING_EXTRA  = 110;
  localparam int COORD_MAX      = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN      = -(1 << (COORD_W - 1));
  localparam int GRID_ORIGIN    = -4000;
  localparam logic [THRESH_W-1:0] LIMIT_TOP = THRESH_W'(1000000);

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [THRESH_W-1:0] cfg_data = '0;

  dgt_point_if pt_ch ();
  dgt_tri_if   tri_ch ();

  int fail_count;
  int outstanding;
  bit gaps_on = 1'b1;
  int col_at = 0;
  int row_at = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  depth_grid_triangulator dut (
    .clk,
    .rst,
    .cfg_write,
    .cfg_data,
    .points    (pt_ch),
    .triangles (tri_ch)
  );

  dgt_mesh_checker mesh_check (
    .clk,
    .rst,
    .cfg_write,
    .cfg_data,
    .points      (pt_ch),
    .triangles   (tri_ch),
    .fail_count,
    .outstanding
  );

  function automatic logic signed [COORD_W-1:0] to_coord(input int v);
    int k;
    k = (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
    return COORD_W'(k);
  endfunction

  function automatic point_t make_point(input int x, input int y, input int z);
    point_t p;
    p.x = to_coord(x);
    p.y = to_coord(y);
    p.z = to_coord(z);
    return p;
  endfunction

  function automatic int spread(input int w);
    return int'($urandom_range(2 * w)) - w;
  endfunction

  // A point on a tilted-free grid at the current raster position.
  function automatic point_t surface_point(input int sp, input int jit, input int zb,
                                           input int zs);
    return make_point(GRID_ORIGIN + col_at * sp + spread(jit),
                      GRID_ORIGIN + row_at * sp + spread(jit), zb + spread(zs));
  endfunction

  function automatic point_t noise_point();
    point_t p;
    p.x = COORD_W'($urandom);
    p.y = COORD_W'($urandom);
    p.z = COORD_W'($urandom);
    return p;
  endfunction

  task automatic send_point(input point_t p, input logic fs);
    int gap;
    gap = gaps_on ? $urandom_range(MAX_GAP) : 0;
    if (gap > 0) begin
      pt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_ch.point_x     <= p.x;
    pt_ch.point_y     <= p.y;
    pt_ch.point_z     <= p.z;
    pt_ch.frame_start <= fs;
    pt_ch.valid       <= 1'b1;
    do @(posedge clk); while (pt_ch.ready !== 1'b1);
    items_sent++;
    if (fs) row_at = 0;
    col_at = fs ? 1 : col_at + 1;
    if (col_at == COLUMNS) begin
      col_at = 0;
      row_at = (row_at + 1) % ROWS;
    end
  endtask

  // Holds the point channel until every predicted triangle has left the block.
  task automatic wait_drained();
    pt_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THRESH_W-1:0] v);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // One row and a bit on a 6 mm grid under the reset limit of 100, so that
  // regular cells pass both triangles, with extreme and borderline points.
  task automatic opening_frame();
    point_t p;
    for (int i = 0; i < COLUMNS + OPENING_EXTRA; i++) begin
      p = surface_point(6, 0, 0, 0);
      case (i)
        60, COLUMNS + 80, COLUMNS + 90: p = make_point(COORD_MIN, COORD_MIN, COORD_MIN);
        61, COLUMNS + 81: p = make_point(COORD_MAX, COORD_MAX, COORD_MAX);
        COLUMNS + 82: p = make_point(COORD_MIN, COORD_MAX, COORD_MIN);
        // Lifted by 8, the left and upper edges land exactly on the limit.
        COLUMNS + 20: p.z = to_coord(8);
        COLUMNS + 30: p.z = to_coord(5);
        COLUMNS + 40: p.z = to_coord(6);
        default: ;
      endcase
      send_point(p, i == 0);
    end
  endtask

  // Restart in the middle of a row; the new row 0 must produce nothing.
  task automatic restart_frame();
    send_point(surface_point(6, 0, 0, 0), 1'b1);
    repeat (RESTART_ITEMS - 1) send_point(surface_point(6, 0, 0, 0), 1'b0);
  endtask

  initial begin
    int                  sp;
    int                  jit;
    int                  zb;
    int                  zs;
    int                  n;
    int                  pick;
    logic [THRESH_W-1:0] lim;
    pt_ch.valid       <= 1'b0;
    pt_ch.point_x     <= '0;
    pt_ch.point_y     <= '0;
    pt_ch.point_z     <= '0;
    pt_ch.frame_start <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    opening_frame();

    while (items_sent < TOTAL_ITEMS - RESTART_ITEMS) begin
      sp  = $urandom_range(12, 1);
      jit = $urandom_range(sp / 2);
      zs  = $urandom_range(sp);
      zb  = int'($urandom_range(8000)) - 4000;
      case ($urandom_range(7))
        0:       lim = '0;
        1:       lim = THRESH_W'(1);
        2:       lim = LIMIT_TOP;
        3:       lim = THRESH_W'($urandom_range(1000000));
        default: lim = THRESH_W'(sp * sp * $urandom_range(4, 1) + $urandom_range(sp * sp));
      endcase
      write_threshold(lim);
      gaps_on = ($urandom_range(3) != 0);
      n = $urandom_range(60, 20);
      if (n > TOTAL_ITEMS - RESTART_ITEMS - items_sent)
        n = TOTAL_ITEMS - RESTART_ITEMS - items_sent;
      repeat (n) begin
        pick = $urandom_range(999);
        if (pick < 60) send_point(noise_point(), 1'b0);
        else if (pick == 60) send_point(noise_point(), 1'b1);
        else send_point(surface_point(sp, jit, zb, zs), 1'b0);
      end
    end

    gaps_on = 1'b1;
    restart_frame();

    pt_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    int stall;
    tri_ch.ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(MAX_GAP) : 0;
      if (stall > 0) begin
        tri_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tri_ch.ready <= 1'b1;
      do @(posedge clk); while (tri_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst || (pt_ch.valid && pt_ch.ready) || (tri_ch.valid && tri_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
